### rtl/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, segment constants and the character font for the multiplexed
// 16-segment display controller.
// ----------------------------------------------------------------------------
package vfd_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PUTCHAR = 2'd1;
    localparam logic [1:0] OP_OVERLAY = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Buffer geometry: ten text positions plus the symbol grid.
    localparam int NUM_POS  = 11;
    localparam int TEXT_POS = 10;
    localparam logic [3:0] LAST_POS = 4'd10;

    // The grid bit of position 0; position p sits p bits lower.
    localparam logic [31:0] GRID0_BIT = 32'h0000_4000;

    // Segment bits.
    localparam logic [31:0] S03 = 32'h1 << 1;
    localparam logic [31:0] S04 = 32'h1 << 0;
    localparam logic [31:0] S05 = 32'h1 << 31;
    localparam logic [31:0] S06 = 32'h1 << 29;
    localparam logic [31:0] S07 = 32'h1 << 30;
    localparam logic [31:0] S08 = 32'h1 << 27;
    localparam logic [31:0] S09 = 32'h1 << 28;
    localparam logic [31:0] S10 = 32'h1 << 25;
    localparam logic [31:0] S11 = 32'h1 << 26;
    localparam logic [31:0] S12 = 32'h1 << 23;
    localparam logic [31:0] S13 = 32'h1 << 24;
    localparam logic [31:0] S14 = 32'h1 << 21;
    localparam logic [31:0] S15 = 32'h1 << 22;
    localparam logic [31:0] S16 = 32'h1 << 19;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } vfd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
    } vfd_status_t;

    // Lower-case letter font.
    localparam logic [31:0] LETTER_FONT [26] = '{
        S03|S05|S04|S10|S09|S15|S14,
        S05|S15|S10|S09|S14|S16,
        S03|S05|S15|S16,
        S15|S10|S09|S16|S04|S14,
        S03|S05|S10|S15|S16,
        S03|S05|S10|S15,
        S03|S05|S15|S16|S11,
        S05|S15|S10|S09|S04|S14,
        S07|S12,
        S04|S14|S16|S15,
        S05|S15|S10|S06|S11,
        S05|S15|S16,
        S05|S15|S03|S07|S04|S14,
        S05|S15|S03|S04|S14,
        S03|S05|S04|S15|S14|S16,
        S03|S05|S04|S15|S10|S09,
        S03|S05|S04|S15|S14|S16|S11,
        S03|S05|S15|S04|S09|S10|S11,
        S03|S05|S10|S09|S14|S16,
        S03|S07|S12,
        S05|S15|S16|S04|S14,
        S05|S15|S13|S06,
        S05|S15|S16|S04|S14|S12,
        S08|S06|S13|S11,
        S08|S06|S12,
        S03|S06|S13|S16|S10|S09
    };

    // Digit font.
    localparam logic [31:0] DIGIT_FONT [10] = '{
        S03|S05|S04|S14|S15|S16,
        S04|S14,
        S03|S04|S10|S09|S15|S16,
        S03|S04|S10|S09|S14|S16,
        S05|S10|S09|S04|S14,
        S03|S05|S10|S09|S14|S16,
        S03|S05|S10|S09|S15|S14|S16,
        S03|S04|S14,
        S03|S05|S04|S10|S09|S15|S14|S16,
        S03|S05|S04|S10|S09|S14|S16
    };

    // Segment pattern of one character byte; unknown codes show the error bar.
    function automatic logic [31:0] glyph(input logic [7:0] code);
        logic [7:0]  off_digit;
        logic [7:0]  off_letter;
        logic [31:0] pat;
        off_digit  = code - 8'h30;
        off_letter = code - 8'h61;
        if (code >= 8'h30 && code <= 8'h39) begin
            pat = DIGIT_FONT[off_digit[3:0]];
        end else if (code >= 8'h61 && code <= 8'h7a) begin
            pat = LETTER_FONT[off_letter[4:0]];
        end else begin
            case (code)
                8'h5f:   pat = S16;
                8'h2d:   pat = S10 | S09;
                8'h2b:   pat = S10 | S09 | S07 | S12;
                8'h3c:   pat = S06 | S11;
                8'h3e:   pat = S08 | S13;
                8'h20:   pat = 32'h0;
                default: pat = S10;
            endcase
        end
        return pat;
    endfunction

endpackage

### rtl/vfd_multiplex_display_controller_top.sv
// ----------------------------------------------------------------------------
// vfd_multiplex_display_controller_top
// Frame buffer and scan controller of an 11-grid 16-segment display.
// ----------------------------------------------------------------------------
// A command word is accepted when start is high and busy is low; busy stays
// high for the single execute cycle, and a new word can be accepted in the
// cycle after it. Clear, put-character and overlay change the buffer in that
// execute cycle and produce nothing. A refresh tick moves the scan position
// (the first tick after reset drives position 1) and puts the driver word and
// grid index on the outputs, with done high for exactly one cycle, in the cycle
// after the execute cycle. The receiver must take the word in that cycle; it is
// held on the ports only until the next tick.
// ----------------------------------------------------------------------------
module vfd_multiplex_display_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [5:0]  char_index,
    input  logic [5:0]  text_length,
    input  logic [31:0] symbol_word,
    output logic        done,
    output logic [31:0] drive_word,
    output logic [3:0]  grid_index
);

    vfd_pkg::vfd_cmd_t    cmd;
    vfd_pkg::vfd_status_t status;

    // Command sequencer.
    vfd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // Buffer and scan datapath.
    vfd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .char_code   (char_code),
        .char_index  (char_index),
        .text_length (text_length),
        .symbol_word (symbol_word),
        .drive_word  (drive_word),
        .grid_index  (grid_index)
    );

    // An accepted word always occupies the execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not enter execute");

    // A result only follows an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execute cycle");

    // The scanned position never leaves the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (grid_index <= vfd_pkg::LAST_POS))
        else $error("grid index out of range");

endmodule

### rtl/vfd_ctrl.sv
// ----------------------------------------------------------------------------
// vfd_ctrl
// Command sequencer: accepts a word, runs it in a single execute state and
// raises the result strobe after a refresh tick.
// ----------------------------------------------------------------------------
module vfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output vfd_pkg::vfd_cmd_t   cmd,
    input  vfd_pkg::vfd_status_t status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = status.is_tick;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Commands to the datapath.
    assign busy     = (state_reg == ST_EXEC);
    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign done     = done_reg;

endmodule

### rtl/vfd_datapath.sv
// ----------------------------------------------------------------------------
// vfd_datapath
// Frame buffer, scan counter and driver-word register of the display.
// ----------------------------------------------------------------------------
module vfd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfd_pkg::vfd_cmd_t    cmd,
    output vfd_pkg::vfd_status_t status,
    input  logic [1:0]           op,
    input  logic [7:0]           char_code,
    input  logic [5:0]           char_index,
    input  logic [5:0]           text_length,
    input  logic [31:0]          symbol_word,
    output logic [31:0]          drive_word,
    output logic [3:0]           grid_index
);

    logic [1:0]  op_reg;
    logic [7:0]  code_reg;
    logic [5:0]  index_reg;
    logic [5:0]  length_reg;
    logic [31:0] symbol_reg;

    logic [31:0] frame_reg [vfd_pkg::NUM_POS];
    logic [31:0] frame_next [vfd_pkg::NUM_POS];
    logic [3:0]  scan_reg;
    logic [3:0]  scan_next;
    logic [31:0] drive_reg;

    logic [3:0]  start_pos;
    logic [6:0]  put_pos;
    logic [31:0] put_glyph;

    // Capture the input word when it is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            op_reg     <= op;
            code_reg   <= char_code;
            index_reg  <= char_index;
            length_reg <= text_length;
            symbol_reg <= symbol_word;
        end
    end

    assign status.is_tick = (op_reg == vfd_pkg::OP_TICK);

    // Right-justified placement of a character.
    assign start_pos = (length_reg < 6'(vfd_pkg::TEXT_POS))
                       ? 4'(6'(vfd_pkg::TEXT_POS) - length_reg) : 4'd0;
    assign put_pos   = {3'b000, start_pos} + {1'b0, index_reg};
    assign put_glyph = vfd_pkg::glyph(code_reg);

    // Next scan position wraps after the symbol grid.
    assign scan_next = (scan_reg == vfd_pkg::LAST_POS) ? 4'd0 : scan_reg + 4'd1;

    // Frame buffer update for the executing operation.
    // Characters only land in the text positions; only clear and overlay write the symbol grid.
    always_comb
    begin
        for (int i = 0; i < vfd_pkg::NUM_POS; i++) begin
            frame_next[i] = frame_reg[i];
            if (cmd.exec) begin
                case (op_reg)
                    vfd_pkg::OP_CLEAR:
                    begin
                        frame_next[i] = 32'h0;
                    end
                    vfd_pkg::OP_PUTCHAR:
                    begin
                        if (put_pos == 7'(i) && i < vfd_pkg::TEXT_POS) begin
                            frame_next[i] = put_glyph;
                        end
                    end
                    vfd_pkg::OP_OVERLAY:
                    begin
                        if ((symbol_reg & (vfd_pkg::GRID0_BIT >> i)) != 32'h0) begin
                            frame_next[i] = frame_reg[i]
                                            | (symbol_reg & ~(vfd_pkg::GRID0_BIT >> i));
                        end
                    end
                    default:
                    begin
                        frame_next[i] = frame_reg[i];
                    end
                endcase
            end
        end
    end

    // The buffer resets to a blank display.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < vfd_pkg::NUM_POS; i++) begin
                frame_reg[i] <= 32'h0;
            end
            scan_reg <= 4'd0;
        end else begin
            for (int i = 0; i < vfd_pkg::NUM_POS; i++) begin
                frame_reg[i] <= frame_next[i];
            end
            if (cmd.exec && status.is_tick) begin
                scan_reg <= scan_next;
            end
        end
    end

    // Driver word of the newly scanned position.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && status.is_tick) begin
            drive_reg <= (vfd_pkg::GRID0_BIT >> scan_next) | frame_reg[scan_next];
        end
    end

    assign drive_word = drive_reg;
    assign grid_index = scan_reg;

endmodule
